// File: src/anrm_pkg.sv
// Package for the axial normal running mean block.
// Holds the operation codes, sequencer states and the count limit; no dependencies.
`timescale 1ns / 1ps
package anrm_pkg;

	localparam int unsigned CountMax = 65535;

	typedef enum logic [1:0] {
		OP_LEARN = 2'd0,
		OP_APPLY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_AVG_MUL,
		ST_AVG_DIV,
		ST_SQ,
		ST_SQRT,
		ST_NRM_DIV,
		ST_DONE
	} state_t;

endpackage

// File: src/axial_normal_running_mean.sv
// Running mean of axial 3-D normals, Q2.14, with sample count; one shared multiplier and divider.
// Apply, clear and learn without averaging register their result straight from idle;
// a good learn on live statistics runs 3 averages and 3 normalizations on a 32-step divider
// and a 16-step square root; a zero-length average skips the normalizations.
// Throughput: s_tready is low from acceptance until the result is registered; a finished
// result waits while m_tready is low. Reset: arst_n clears mean, count and handshake state.
`timescale 1ns / 1ps
module axial_normal_running_mean
	import anrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] operation, [17:2] normal_x, [33:18] normal_y, [49:34] normal_z, pad to 56
	input  logic [55:0] s_tdata,
	// [0] good_example
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] adjusted_x, [31:16] adjusted_y, [47:32] adjusted_z
	output logic [47:0] m_tdata,
	// [0] stats_valid
	output logic        m_tuser
);

	localparam int DW = 32; // divider operand width

	state_t state_q, state_d;

	logic signed [15:0] mean_q [3];
	logic [15:0]        count_q;
	logic signed [16:0] v_q [3];
	logic               good_q;
	op_t                op_q;
	logic [1:0]         idx_q;
	logic signed [17:0] a_q [3];
	logic signed [35:0] acc_q;
	logic [5:0]         step_q;
	logic               busy_q;
	logic [15:0]        out_q [3];
	logic               stv_q;

	// shared divider: |num| / den, restoring, one bit per cycle
	logic [DW-1:0] dnum_q, dden_q, drem_q;
	logic          dneg_q;
	// square root state
	logic [31:0]   sq_s_q, sq_bit_q, sq_r_q;

	logic               s_acc;
	logic               out_free;
	logic               nz;
	logic               long_path;
	logic               short_fin;
	logic               fin;
	logic               div_end;
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] mul_p;
	logic signed [35:0] acc_sum;
	logic signed [33:0] avg_num;
	logic [33:0]        avg_mag;
	logic [16:0]        den_avg;
	logic [DW:0]        trial;
	logic [31:0]        sq_tr;
	logic [1:0]         nrm_idx;
	logic signed [17:0] nrm_a;
	logic [17:0]        nrm_mag;
	logic signed [17:0] quo18;
	logic signed [15:0] quo16;

	function automatic logic [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) return 16'h7fff;
		if (v < -18'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	// handshake and item classification
	assign s_tready  = !busy_q;
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign nz        = (v_q[0] != '0) || (v_q[1] != '0) || (v_q[2] != '0);
	assign long_path = (op_q == OP_LEARN) && nz && (count_q != '0) && good_q;
	assign short_fin = (state_q == ST_IDLE) && busy_q && !long_path && out_free;
	assign fin       = short_fin || ((state_q == ST_DONE) && out_free);
	assign div_end   = (step_q == 6'(DW));

	// single shared multiplier
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DOT: begin
				mul_a = 18'(mean_q[idx_q]);
				mul_b = 18'(v_q[idx_q]);
			end
			ST_AVG_MUL: begin
				mul_a = 18'(mean_q[idx_q]);
				mul_b = 18'({1'b0, count_q});
			end
			ST_SQ: begin
				mul_a = a_q[idx_q];
				mul_b = a_q[idx_q];
			end
			default: ;
		endcase
	end

	assign acc_sum = acc_q + mul_p;

	// average numerator m*n + v, rounded by adding half the divisor to the magnitude
	assign avg_num = 34'(mul_p) + 34'(v_q[idx_q]);
	assign avg_mag = avg_num[33] ? 34'(-avg_num) : 34'(avg_num);
	assign den_avg = {1'b0, count_q} + 17'd1;

	// normalization operand for the next component
	assign nrm_idx = (state_q == ST_SQRT || idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
	assign nrm_a   = a_q[nrm_idx];
	assign nrm_mag = nrm_a[17] ? 18'(-nrm_a) : 18'(nrm_a);

	assign trial = {drem_q, dnum_q[DW-1]} - {1'b0, dden_q};
	assign quo18 = signed'(dnum_q[17:0]);
	assign quo16 = signed'(dnum_q[15:0]);

	assign sq_tr = sq_r_q + sq_bit_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (busy_q && long_path) state_d = ST_DOT;
			ST_DOT:     if (idx_q == 2'd2) state_d = ST_AVG_MUL;
			ST_AVG_MUL: state_d = ST_AVG_DIV;
			ST_AVG_DIV: if (div_end) state_d = (idx_q == 2'd2) ? ST_SQ : ST_AVG_MUL;
			ST_SQ:      if (idx_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT:    if (sq_bit_q == '0) state_d = (acc_q == '0) ? ST_DONE : ST_NRM_DIV;
			ST_NRM_DIV: if (div_end && idx_q == 2'd2) state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mean_q[i] <= '0;
				v_q[i]    <= '0;
				a_q[i]    <= '0;
				out_q[i]  <= '0;
			end
			count_q  <= '0;
			op_q     <= OP_LEARN;
			good_q   <= 1'b0;
			busy_q   <= 1'b0;
			m_tvalid <= 1'b0;
			stv_q    <= 1'b0;
			idx_q    <= '0;
			acc_q    <= '0;
			step_q   <= '0;
			dnum_q   <= '0;
			dden_q   <= '0;
			drem_q   <= '0;
			dneg_q   <= 1'b0;
			sq_s_q   <= '0;
			sq_bit_q <= '0;
			sq_r_q   <= '0;
		end else begin
			// result transaction
			if (fin) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (s_acc) busy_q <= 1'b1;
			else if (fin) busy_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						op_q   <= op_t'(s_tdata[1:0]);
						v_q[0] <= 17'(signed'(s_tdata[17:2]));
						v_q[1] <= 17'(signed'(s_tdata[33:18]));
						v_q[2] <= 17'(signed'(s_tdata[49:34]));
						good_q <= s_tuser;
						idx_q  <= '0;
						acc_q  <= '0;
					end else if (short_fin) begin
						// operations that finish without the iterative path
						if (op_q == OP_LEARN && nz && count_q == '0) begin
							if (good_q) begin
								for (int i = 0; i < 3; i++) mean_q[i] <= v_q[i][15:0];
								count_q <= 16'd1;
							end
							for (int i = 0; i < 3; i++) out_q[i] <= '0;
							stv_q <= good_q;
						end else if ((op_q == OP_LEARN && nz) ||
								(op_q == OP_APPLY && count_q != '0)) begin
							for (int i = 0; i < 3; i++)
								out_q[i] <= sat16(18'(v_q[i]) - 18'(mean_q[i]));
							stv_q <= 1'b1;
						end else begin
							if (op_q == OP_CLEAR) begin
								for (int i = 0; i < 3; i++) mean_q[i] <= '0;
								count_q <= '0;
							end
							for (int i = 0; i < 3; i++) out_q[i] <= v_q[i][15:0];
							stv_q <= (op_q != OP_CLEAR) && (count_q != '0);
						end
					end
				end
				ST_DOT: begin
					acc_q <= acc_sum;
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2 && acc_sum < 0)
						for (int i = 0; i < 3; i++) v_q[i] <= -v_q[i];
				end
				ST_AVG_MUL: begin
					dneg_q <= avg_num[33];
					dnum_q <= DW'(avg_mag) + DW'(den_avg >> 1);
					dden_q <= DW'(den_avg);
					drem_q <= '0;
					step_q <= '0;
				end
				ST_AVG_DIV, ST_NRM_DIV: begin
					if (!div_end) begin
						drem_q <= trial[DW] ? {drem_q[DW-2:0], dnum_q[DW-1]} : trial[DW-1:0];
						dnum_q <= {dnum_q[DW-2:0], ~trial[DW]};
						step_q <= step_q + 6'd1;
					end else if (state_q == ST_AVG_DIV) begin
						a_q[idx_q] <= dneg_q ? -quo18 : quo18;
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						if (idx_q == 2'd2) acc_q <= '0;
					end else begin
						mean_q[idx_q] <= dneg_q ? -quo16 : quo16;
						if (idx_q == 2'd2) begin
							if (count_q != 16'(CountMax)) count_q <= count_q + 16'd1;
							idx_q <= '0;
						end else begin
							// load the next component
							dneg_q <= nrm_a[17];
							dnum_q <= DW'({nrm_mag, 14'd0}) + (sq_r_q >> 1);
							dden_q <= sq_r_q;
							drem_q <= '0;
							step_q <= '0;
							idx_q  <= idx_q + 2'd1;
						end
					end
				end
				ST_SQ: begin
					acc_q <= acc_sum;
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						sq_s_q   <= 32'(acc_sum);
						sq_r_q   <= '0;
						sq_bit_q <= 32'h4000_0000;
					end
				end
				ST_SQRT: begin
					if (sq_bit_q != '0) begin
						if (sq_s_q >= sq_tr) begin
							sq_s_q <= sq_s_q - sq_tr;
							sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
						end else begin
							sq_r_q <= sq_r_q >> 1;
						end
						sq_bit_q <= sq_bit_q >> 2;
					end else if (acc_q == '0) begin
						// zero length drops the statistics
						for (int i = 0; i < 3; i++) mean_q[i] <= '0;
						count_q <= '0;
					end else begin
						dneg_q <= nrm_a[17];
						dnum_q <= DW'({nrm_mag, 14'd0}) + (sq_r_q >> 1);
						dden_q <= sq_r_q;
						drem_q <= '0;
						step_q <= '0;
						idx_q  <= '0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++)
							out_q[i] <= sat16(18'(v_q[i]) - 18'(mean_q[i]));
						stv_q <= count_q != '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tdata = {out_q[2], out_q[1], out_q[0]};
	assign m_tuser = stv_q;

	// a waiting result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser));
	// input is taken only while the sequencer idles
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE);
	// sequencer runs only with an item at work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> busy_q);
	// divider step count stays in range
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 6'(DW));

endmodule

// File: sim/anrm_checker.sv
// Checker for the axial normal running mean block: watches both stream channels,
// predicts each result from its own copy of mean and count, and counts mismatches.
// Depends on anrm_pkg for the operation codes.
`timescale 1ns / 1ps
module anrm_checker
	import anrm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic        valid;
	} adj_t;

	adj_t adj_q[$];
	longint mx, my, mz;
	longint cnt;

	assign pending = adj_q.size();

	// round to nearest, halves away from zero; den > 0
	function automatic longint rdiv(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic [15:0] sat(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// advance the mean model by one item and return the expected result
	function automatic adj_t predict_adjusted(logic [55:0] d, logic good);
		op_t op;
		longint v[3], m[3], o[3], a[3];
		longint dot, s, len, n, lo, hi, mid;
		adj_t r;
		op = op_t'(d[1:0]);
		v[0] = longint'($signed(d[17:2]));
		v[1] = longint'($signed(d[33:18]));
		v[2] = longint'($signed(d[49:34]));
		m[0] = mx; m[1] = my; m[2] = mz;
		o = v;
		if (op == OP_LEARN) begin
			if (v[0] != 0 || v[1] != 0 || v[2] != 0) begin
				if (cnt == 0) begin
					if (good) begin
						mx = v[0]; my = v[1]; mz = v[2];
						cnt = 1;
					end
					o[0] = 0; o[1] = 0; o[2] = 0;
				end else begin
					if (good) begin
						n = cnt;
						dot = m[0] * v[0] + m[1] * v[1] + m[2] * v[2];
						if (dot < 0)
							for (int i = 0; i < 3; i++) v[i] = -v[i];
						s = 0;
						for (int i = 0; i < 3; i++) begin
							a[i] = rdiv(m[i] * n + v[i], n + 1);
							s += a[i] * a[i];
						end
						if (s == 0) begin
							m[0] = 0; m[1] = 0; m[2] = 0;
							cnt = 0;
						end else begin
							// binary search square root
							lo = 0; hi = 65536;
							while (lo < hi) begin
								mid = (lo + hi + 1) / 2;
								if (mid * mid <= s) lo = mid;
								else hi = mid - 1;
							end
							len = lo;
							for (int i = 0; i < 3; i++) m[i] = rdiv(a[i] * 16384, len);
							if (cnt < CountMax) cnt++;
						end
						mx = m[0]; my = m[1]; mz = m[2];
					end
					for (int i = 0; i < 3; i++) o[i] = v[i] - m[i];
				end
			end
		end else if (op == OP_APPLY) begin
			if (cnt != 0)
				for (int i = 0; i < 3; i++) o[i] = v[i] - m[i];
		end else if (op == OP_CLEAR) begin
			mx = 0; my = 0; mz = 0; cnt = 0;
		end
		r.ax = sat(o[0]);
		r.ay = sat(o[1]);
		r.az = sat(o[2]);
		r.valid = (cnt != 0);
		return r;
	endfunction

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		adj_t e;
		if (!arst_n) begin
			mx = 0; my = 0; mz = 0; cnt = 0;
			errors = 0;
			adj_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (adj_q.size() == 0) begin
					$error("unexpected result transaction %h", m_tdata);
					errors++;
				end else begin
					e = adj_q.pop_front();
					if (m_tdata[15:0] !== e.ax) begin
						$error("adjusted_x exp %h got %h", e.ax, m_tdata[15:0]);
						errors++;
					end
					if (m_tdata[31:16] !== e.ay) begin
						$error("adjusted_y exp %h got %h", e.ay, m_tdata[31:16]);
						errors++;
					end
					if (m_tdata[47:32] !== e.az) begin
						$error("adjusted_z exp %h got %h", e.az, m_tdata[47:32]);
						errors++;
					end
					if (m_tuser !== e.valid) begin
						$error("stats_valid exp %b got %b", e.valid, m_tuser);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				adj_q = {adj_q, predict_adjusted(s_tdata, s_tuser)};
		end
	end

endmodule

// File: sim/tb_axial_normal_running_mean.sv
// Testbench top for axial_normal_running_mean: drives directed and random
// transactions with random gaps and stalls; the verdict comes from anrm_checker.
`timescale 1ns / 1ps
module tb_axial_normal_running_mean
	import anrm_pkg::*;
();

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	int          errors;
	int          pending;
	bit          calm = 0;

	always #2 clk = ~clk;

	axial_normal_running_mean uut (.*);

	anrm_checker chk (.*);

	// receiver stalls in bursts
	initial begin
		int k;
		wait (arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, 11);
				m_tready <= 0;
				repeat (k) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_normal(op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic good);
		int k;
		if (!calm && $urandom_range(0, 3) == 0) begin
			k = $urandom_range(1, 11);
			s_tvalid <= 0;
			repeat (k) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'b0, z, y, x, op};
		s_tuser <= good;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// random unit-ish vector near a chosen axis, with random sign
	task automatic send_axis_sample(int bx, int by, int bz, logic good);
		int sg;
		sg = $urandom_range(0, 1) ? -1 : 1;
		send_normal(OP_LEARN, 16'(sg * (bx + $signed($urandom_range(0, 2000)) - 1000)),
			16'(sg * (by + $signed($urandom_range(0, 2000)) - 1000)),
			16'(sg * (bz + $signed($urandom_range(0, 2000)) - 1000)), good);
	endtask

	initial begin
		int bx, by, bz;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty stats, seeding, extremes, flips, zero length, every op
		send_normal(OP_APPLY, 16'h8000, 16'h7fff, 16'h0000, 1);
		send_normal(OP_LEARN, 16'h0000, 16'h0000, 16'h0000, 1);
		send_normal(OP_LEARN, 16'h4000, 16'h0000, 16'h0000, 0);
		send_normal(OP_LEARN, 16'h4000, 16'h0000, 16'h0000, 1);
		send_normal(OP_LEARN, 16'hc000, 16'h0010, 16'h0000, 1);
		send_normal(OP_LEARN, 16'h8000, 16'h8000, 16'h8000, 1);
		send_normal(OP_LEARN, 16'h7fff, 16'h7fff, 16'h7fff, 1);
		send_normal(OP_LEARN, 16'h8000, 16'h7fff, 16'h8000, 0);
		send_normal(OP_APPLY, 16'h8000, 16'h8000, 16'h8000, 0);
		send_normal(OP_APPLY, 16'h0000, 16'h0000, 16'h0000, 0);
		send_normal(OP_NONE, 16'h1234, 16'hfedc, 16'h8000, 1);
		send_normal(OP_CLEAR, 16'h7fff, 16'h8000, 16'h0001, 1);
		// tiny vectors: seed (1,0,0), then rounding of the average and a flipped sample
		send_normal(OP_LEARN, 16'h0001, 16'h0000, 16'h0000, 1);
		send_normal(OP_LEARN, 16'h0000, 16'h0002, 16'h0000, 1);
		send_normal(OP_LEARN, 16'hfffe, 16'h0000, 16'h0000, 1);
		send_normal(OP_APPLY, 16'h0100, 16'h0100, 16'h0100, 1);
		send_normal(OP_LEARN, 16'h0000, 16'h0000, 16'h4000, 1);
		send_normal(OP_LEARN, 16'h0000, 16'h0000, 16'hc000, 1);
		send_normal(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 0);
		// hold off until the block has drained
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// random: mostly learn runs around an axis, plus applies, clears and noise
		for (int i = 0; i < 1880; i++) begin
			if (i == 1700)
				calm = 1;
			if (i % 150 == 0) begin
				bx = $signed($urandom_range(0, 32768)) - 16384;
				by = $signed($urandom_range(0, 32768)) - 16384;
				bz = $signed($urandom_range(0, 32768)) - 16384;
			end
			case ($urandom_range(0, 19))
				0: send_normal(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
				1: send_normal(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
				2, 3: send_normal(OP_APPLY, 16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
				4, 5: send_normal(OP_LEARN, 16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
				6: send_normal(OP_LEARN, 16'h0, 16'h0, 16'h0, 1'($urandom));
				7: send_axis_sample(bx, by, bz, 0);
				default: send_axis_sample(bx, by, bz, 1);
			endcase
		end
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
